// ----- design/ots_pkg.sv -----
// shared types, constants and control store for the one-shot timer slot table
package ots_pkg;

  localparam int NUM_SLOTS = 20;
  localparam int SLOT_W    = 5;
  localparam int TPS_W     = 24;
  localparam int TIME_W    = 32;
  localparam int DIV_CNT_W = 5;

  localparam logic [TPS_W-1:0]     TPS_RESET     = 24'd1000000;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(TPS_W - 1);
  localparam logic [SLOT_W-1:0]    LAST_SLOT     = SLOT_W'(NUM_SLOTS - 1);

  localparam logic [1:0] KIND_ATTACH  = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_ZERO_RATE = 2'd2;

  localparam logic OP_ATTACH = 1'b0;
  localparam logic OP_POLL   = 1'b1;

  typedef struct packed {
    logic              op;
    logic [TPS_W-1:0]  rate_hz;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        status;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [TPS_W-1:0]  interval;
    logic [TIME_W-1:0] start_time;
  } slot_entry_t;

  typedef enum logic [3:0] {
    U_IDLE,
    U_DISPATCH,
    U_A_CHK,
    U_A_DIV,
    U_A_WR,
    U_A_OUT,
    U_P_RD,
    U_P_CMP,
    U_P_EMIT
  } upc_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_OP_POLL,
    C_ATT_ERR,
    C_DIV_LAST,
    C_OUT_FREE,
    C_SCAN_DONE,
    C_EMIT_END
  } cond_t;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_ATT_CHECK,
    ACT_DIV_STEP,
    ACT_ATT_WRITE,
    ACT_ATT_EMIT,
    ACT_SLOT_READ,
    ACT_SLOT_CMP,
    ACT_POLL_EMIT
  } act_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  jt;
    upc_t  jf;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic op_poll;
    logic att_err;
    logic div_last;
    logic out_free;
    logic scan_done;
    logic emit_end;
  } flags_t;

  // control store: action, branch condition, target when true, target when false
  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    case (pc)
      U_IDLE:     w = '{ACT_ACCEPT,    C_IN_VALID,  U_DISPATCH, U_IDLE};
      U_DISPATCH: w = '{ACT_NOP,       C_OP_POLL,   U_P_RD,     U_A_CHK};
      U_A_CHK:    w = '{ACT_ATT_CHECK, C_ATT_ERR,   U_A_OUT,    U_A_DIV};
      U_A_DIV:    w = '{ACT_DIV_STEP,  C_DIV_LAST,  U_A_WR,     U_A_DIV};
      U_A_WR:     w = '{ACT_ATT_WRITE, C_ALWAYS,    U_A_OUT,    U_A_OUT};
      U_A_OUT:    w = '{ACT_ATT_EMIT,  C_OUT_FREE,  U_IDLE,     U_A_OUT};
      U_P_RD:     w = '{ACT_SLOT_READ, C_ALWAYS,    U_P_CMP,    U_P_CMP};
      U_P_CMP:    w = '{ACT_SLOT_CMP,  C_SCAN_DONE, U_P_EMIT,   U_P_RD};
      U_P_EMIT:   w = '{ACT_POLL_EMIT, C_EMIT_END,  U_IDLE,     U_P_EMIT};
      default:    w = '{ACT_NOP,       C_ALWAYS,    U_IDLE,     U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- design/ots_div.sv -----
// serial restoring divider, one quotient bit per step
module ots_div (
  input  logic                         clk,
  input  logic                         start,
  input  logic                         step,
  input  logic [ots_pkg::TPS_W-1:0]    dividend,
  input  logic [ots_pkg::TPS_W-1:0]    divisor,
  output logic [ots_pkg::TPS_W-1:0]    quotient,
  output logic                         last_step
);

  logic [ots_pkg::TPS_W:0]         rem_r, rem_nxt, rem_sh;
  logic [ots_pkg::TPS_W-1:0]       quo_r, quo_nxt;
  logic [ots_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                            ge;

  always_comb begin
    rem_sh  = {rem_r[ots_pkg::TPS_W-1:0], quo_r[ots_pkg::TPS_W-1]};
    ge      = rem_sh >= {1'b0, divisor};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = '0;
    end else if (step) begin
      rem_nxt = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
      quo_nxt = {quo_r[ots_pkg::TPS_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quotient  = quo_r;
  assign last_step = cnt_r == ots_pkg::DIV_LAST_STEP;

endmodule

// ----- design/ots_dp.sv -----
// datapath: slot memory, active bits, expiry mask, divider and result register
module ots_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ots_pkg::act_t               act,
  input  logic                        in_valid,
  input  ots_pkg::in_item_t           in_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output ots_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [ots_pkg::TPS_W-1:0]   cfg_wdata,
  output ots_pkg::flags_t             flags
);

  ots_pkg::slot_entry_t mem [ots_pkg::NUM_SLOTS];
  ots_pkg::slot_entry_t rd_r;

  logic [ots_pkg::TPS_W-1:0]     tps_r;
  ots_pkg::in_item_t             item_r;
  logic [ots_pkg::NUM_SLOTS-1:0] active_r;
  logic [ots_pkg::NUM_SLOTS-1:0] mask_r;
  logic [ots_pkg::SLOT_W-1:0]    idx_r;
  logic [ots_pkg::SLOT_W-1:0]    free_r;
  logic [1:0]                    status_r;
  logic                          out_valid_r;
  ots_pkg::out_item_t            out_r;

  logic [ots_pkg::SLOT_W-1:0]    free_idx, low_idx;
  logic                          full, att_err, out_free, expire;
  logic [1:0]                    att_status;
  logic [ots_pkg::NUM_SLOTS-1:0] rest;
  logic [ots_pkg::TIME_W-1:0]    elapsed;
  logic [ots_pkg::TPS_W-1:0]     quotient;
  logic                          div_last;
  logic                          accept;
  logic                          load_out;

  ots_div u_div (
    .clk       (clk),
    .start     (act == ots_pkg::ACT_ATT_CHECK),
    .step      (act == ots_pkg::ACT_DIV_STEP),
    .dividend  (tps_r),
    .divisor   (item_r.rate_hz),
    .quotient  (quotient),
    .last_step (div_last)
  );

  // lowest free slot and lowest pending expiry
  always_comb begin
    free_idx = '0;
    low_idx  = '0;
    for (int i = ots_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) free_idx = ots_pkg::SLOT_W'(i);
      if (mask_r[i])    low_idx  = ots_pkg::SLOT_W'(i);
    end
  end

  always_comb begin
    full       = &active_r;
    att_status = full                   ? ots_pkg::ST_FULL :
                 (item_r.rate_hz == '0) ? ots_pkg::ST_ZERO_RATE : ots_pkg::ST_OK;
    att_err    = att_status != ots_pkg::ST_OK;
    out_free   = !out_valid_r || out_ready;
    rest       = mask_r & ~(ots_pkg::NUM_SLOTS'(1) << low_idx);
    elapsed    = item_r.now_time - rd_r.start_time;
    expire     = active_r[idx_r] && (elapsed > {8'b0, rd_r.interval});
    accept     = in_valid && (act == ots_pkg::ACT_ACCEPT);
    load_out   = out_free && ((act == ots_pkg::ACT_ATT_EMIT) ||
                              (act == ots_pkg::ACT_POLL_EMIT));
  end

  always_comb begin
    flags.in_valid  = in_valid;
    flags.op_poll   = item_r.op == ots_pkg::OP_POLL;
    flags.att_err   = att_err;
    flags.div_last  = div_last;
    flags.out_free  = out_free;
    flags.scan_done = idx_r == ots_pkg::LAST_SLOT;
    flags.emit_end  = out_free && ((mask_r == '0) || (rest == '0));
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (act == ots_pkg::ACT_ATT_WRITE) begin
      mem[free_r] <= '{interval: quotient, start_time: item_r.now_time};
    end
    if (act == ots_pkg::ACT_SLOT_READ) begin
      rd_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    if (act == ots_pkg::ACT_ATT_CHECK) begin
      free_r   <= free_idx;
      status_r <= att_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= ots_pkg::TPS_RESET;
      active_r    <= '0;
      mask_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) tps_r <= cfg_wdata;
      out_valid_r <= load_out || (out_valid_r && !out_ready);
      case (act)
        ots_pkg::ACT_ACCEPT: begin
          idx_r  <= '0;
          mask_r <= '0;
        end
        ots_pkg::ACT_ATT_WRITE: begin
          active_r[free_r] <= 1'b1;
        end
        ots_pkg::ACT_ATT_EMIT: begin
          if (out_free) begin
            out_r.kind   <= ots_pkg::KIND_ATTACH;
            out_r.slot   <= (status_r == ots_pkg::ST_OK) ? free_r : '0;
            out_r.status <= status_r;
            out_r.last   <= 1'b1;
          end
        end
        ots_pkg::ACT_SLOT_CMP: begin
          if (expire) begin
            mask_r[idx_r]   <= 1'b1;
            active_r[idx_r] <= 1'b0;
          end
          if (idx_r != ots_pkg::LAST_SLOT) idx_r <= idx_r + 1'b1;
        end
        ots_pkg::ACT_POLL_EMIT: begin
          if (out_free) begin
            out_r.status <= ots_pkg::ST_OK;
            out_r.last   <= (mask_r == '0) || (rest == '0);
            if (mask_r == '0) begin
              out_r.kind <= ots_pkg::KIND_NONE;
              out_r.slot <= '0;
            end else begin
              out_r.kind <= ots_pkg::KIND_EXPIRED;
              out_r.slot <= low_idx;
              mask_r     <= rest;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/ots_useq.sv -----
// micro-sequencer: step counter, control store lookup and conditional branch
module ots_useq (
  input  logic             clk,
  input  logic             rst_n,
  input  ots_pkg::flags_t  flags,
  output ots_pkg::act_t    act
);

  ots_pkg::upc_t   upc_r, upc_nxt;
  ots_pkg::uword_t uw;
  logic            take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ots_pkg::U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  always_comb begin
    uw = ots_pkg::ucode(upc_r);
    case (uw.cond)
      ots_pkg::C_ALWAYS:    take = 1'b1;
      ots_pkg::C_IN_VALID:  take = flags.in_valid;
      ots_pkg::C_OP_POLL:   take = flags.op_poll;
      ots_pkg::C_ATT_ERR:   take = flags.att_err;
      ots_pkg::C_DIV_LAST:  take = flags.div_last;
      ots_pkg::C_OUT_FREE:  take = flags.out_free;
      ots_pkg::C_SCAN_DONE: take = flags.scan_done;
      ots_pkg::C_EMIT_END:  take = flags.emit_end;
      default:              take = 1'b1;
    endcase
    upc_nxt = take ? uw.jt : uw.jf;
    act     = uw.act;
  end

endmodule

// ----- design/one_shot_timer_slot_table.sv -----
// top level of the one-shot timer slot table
// Usage:
//   in_valid/in_ready/in_data carries one request beat: op 0 attaches a timer at
//   rate_hz with start time now_time, op 1 polls at time now_time.
//   out_valid/out_ready/out_data returns result beats; the final beat of a
//   request has last set. cfg_we/cfg_wdata write ticks_per_second at any edge
//   while no request is in flight.
// Timing: one request at a time. An attach result waits for the check, the
//   24-step serial divider and the slot write; error replies skip the divider.
//   A poll reads the 20 slots through the single memory read port, a read and
//   a compare step each; its first result follows the scan, then one beat per
//   cycle unless out_ready stalls. in_ready rises the cycle after the final load.
// Reset: rst_n low for one edge frees every slot, restores ticks_per_second to
//   1000000 and drops out_valid; slot memory contents are not cleared.
// Stall: while out_ready is low the result register holds its beat and the
//   sequencer waits at the emit step; a new request may still be accepted
//   while the last result of the previous one waits.
module one_shot_timer_slot_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ots_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ots_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [ots_pkg::TPS_W-1:0]   cfg_wdata
);

  ots_pkg::act_t   act;
  ots_pkg::flags_t flags;

  ots_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .act   (act)
  );

  ots_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .act       (act),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .flags     (flags)
  );

  assign in_ready = act == ots_pkg::ACT_ACCEPT;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_attach_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == ots_pkg::KIND_ATTACH) |-> out_data.last)
    else $error("attach reply without last");

  a_poll_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind != ots_pkg::KIND_ATTACH) |-> out_data.status == ots_pkg::ST_OK)
    else $error("poll result with nonzero status");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.slot <= ots_pkg::LAST_SLOT)
    else $error("slot number out of range");
`endif

endmodule

// ----- tb/tb_one_shot_timer_slot_table.sv -----
// testbench for the one-shot timer slot table: attach and poll traffic checked against a predictor
`timescale 1ns / 1ps

module tb_one_shot_timer_slot_table;

  class timer_slot_scoreboard;
    logic [ots_pkg::TPS_W-1:0]  tick_rate;
    bit                         armed [ots_pkg::NUM_SLOTS];
    logic [ots_pkg::TPS_W-1:0]  period [ots_pkg::NUM_SLOTS];
    logic [ots_pkg::TIME_W-1:0] origin [ots_pkg::NUM_SLOTS];
    ots_pkg::out_item_t         replies_due [$];
    int mismatches;
    int requests;
    int attaches_ok;
    int full_seen;
    int zero_rate_seen;
    int expiries;
    int empty_polls;

    function new();
      tick_rate = ots_pkg::TPS_RESET;
      foreach (armed[i]) armed[i] = 1'b0;
      mismatches = 0;
      requests = 0;
      attaches_ok = 0;
      full_seen = 0;
      zero_rate_seen = 0;
      expiries = 0;
      empty_polls = 0;
    endfunction

    function void add_reply(logic [1:0] kind, int slot, logic [1:0] status, logic last);
      ots_pkg::out_item_t r;
      r.kind = kind;
      r.slot = ots_pkg::SLOT_W'(slot);
      r.status = status;
      r.last = last;
      replies_due.push_back(r);
    endfunction

    // works out the replies of one accepted request and updates the slot table
    function void note_request(ots_pkg::in_item_t req);
      int free_slot;
      int fired;
      logic [ots_pkg::TIME_W-1:0] elapsed;
      ots_pkg::out_item_t tail;
      free_slot = -1;
      fired = 0;
      requests++;
      if (req.op == ots_pkg::OP_ATTACH) begin
        for (int i = 0; i < ots_pkg::NUM_SLOTS; i++) begin
          if (!armed[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot < 0) begin
          full_seen++;
          add_reply(ots_pkg::KIND_ATTACH, 0, ots_pkg::ST_FULL, 1'b1);
        end else if (req.rate_hz == '0) begin
          zero_rate_seen++;
          add_reply(ots_pkg::KIND_ATTACH, 0, ots_pkg::ST_ZERO_RATE, 1'b1);
        end else begin
          armed[free_slot] = 1'b1;
          period[free_slot] = tick_rate / req.rate_hz;
          origin[free_slot] = req.now_time;
          attaches_ok++;
          add_reply(ots_pkg::KIND_ATTACH, free_slot, ots_pkg::ST_OK, 1'b1);
        end
      end else begin
        for (int i = 0; i < ots_pkg::NUM_SLOTS; i++) begin
          if (armed[i]) begin
            elapsed = req.now_time - origin[i];
            if (elapsed > ots_pkg::TIME_W'(period[i])) begin
              armed[i] = 1'b0;
              fired++;
              add_reply(ots_pkg::KIND_EXPIRED, i, ots_pkg::ST_OK, 1'b0);
            end
          end
        end
        expiries += fired;
        if (fired == 0) begin
          empty_polls++;
          add_reply(ots_pkg::KIND_NONE, 0, ots_pkg::ST_OK, 1'b1);
        end else begin
          tail = replies_due.pop_back();
          tail.last = 1'b1;
          replies_due.push_back(tail);
        end
      end
    endfunction

    function void complain(string what, ots_pkg::out_item_t want, ots_pkg::out_item_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t: %s: expected kind=%0d slot=%0d status=%0d last=%0d, ",
                  "got kind=%0d slot=%0d status=%0d last=%0d"},
                 $realtime, what, want.kind, want.slot, want.status, want.last,
                 got.kind, got.slot, got.status, got.last);
    endfunction

    function void check_reply(ots_pkg::out_item_t got);
      ots_pkg::out_item_t want;
      if (replies_due.size() == 0) begin
        want = '0;
        complain("reply with nothing pending", want, got);
      end else begin
        want = replies_due.pop_front();
        if (got.kind !== want.kind || got.slot !== want.slot ||
            got.status !== want.status || got.last !== want.last)
          complain("reply mismatch", want, got);
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  ots_pkg::in_item_t           in_data;
  logic                        out_valid;
  logic                        out_ready;
  ots_pkg::out_item_t          out_data;
  logic                        cfg_we;
  logic [ots_pkg::TPS_W-1:0]   cfg_wdata;

  timer_slot_scoreboard        sb = new();
  bit                          quiet = 1'b0;
  logic [ots_pkg::TIME_W-1:0]  cursor_us;

  one_shot_timer_slot_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_reply(out_data);
  end

  // result side backpressure
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  function automatic ots_pkg::in_item_t request(logic op, logic [ots_pkg::TPS_W-1:0] rate,
                                                logic [ots_pkg::TIME_W-1:0] now);
    ots_pkg::in_item_t it;
    it.op = op;
    it.rate_hz = rate;
    it.now_time = now;
    return it;
  endfunction

  // valid stays high after the beat; the caller sends again or lowers it
  task automatic send_request(input ots_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_tick_rate(input logic [ots_pkg::TPS_W-1:0] value);
    drain_replies();
    // let the sequencer settle back to idle after its last beat
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.tick_rate = value;
  endtask

  task automatic next_request(output ots_pkg::in_item_t it);
    int pick;
    int live [$];
    int s;
    it.op = ($urandom_range(0, 99) < 55) ? ots_pkg::OP_ATTACH : ots_pkg::OP_POLL;
    pick = $urandom_range(0, 99);
    if (pick < 6)       it.rate_hz = '0;
    else if (pick < 30) it.rate_hz = ots_pkg::TPS_W'($urandom_range(1, 16));
    else if (pick < 55) it.rate_hz = ots_pkg::TPS_W'($urandom_range(17, 100000));
    else if (pick < 95) it.rate_hz = ots_pkg::TPS_W'($urandom());
    else                it.rate_hz = '1;
    foreach (sb.armed[i]) if (sb.armed[i]) live.push_back(i);
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      it.now_time = $urandom();
    end else if (it.op == ots_pkg::OP_POLL && pick < 40 && live.size() != 0) begin
      // land right on or just past a live slot's deadline
      s = live[$urandom_range(0, live.size() - 1)];
      cursor_us = sb.origin[s] + ots_pkg::TIME_W'(sb.period[s]) +
                  ots_pkg::TIME_W'($urandom_range(0, 1));
      it.now_time = cursor_us;
    end else begin
      if (pick < 60)      cursor_us += ots_pkg::TIME_W'($urandom_range(0, 3));
      else if (pick < 85) cursor_us += ots_pkg::TIME_W'($urandom_range(0, 2000));
      else                cursor_us += ots_pkg::TIME_W'($urandom_range(0, 20000000));
      it.now_time = cursor_us;
    end
  endtask

  initial begin
    logic [ots_pkg::TPS_W-1:0] tick_plan [5];
    ots_pkg::in_item_t         it;
    int                        phases;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero rate with slots free, fill the table, overflow, then expire with wrap
    sender_gap();
    send_request(request(ots_pkg::OP_ATTACH, '0, '0));
    for (int i = 0; i < ots_pkg::NUM_SLOTS; i++) begin
      sender_gap();
      if (i == ots_pkg::NUM_SLOTS - 1) send_request(request(ots_pkg::OP_ATTACH, '1, '1));
      else send_request(request(ots_pkg::OP_ATTACH, ots_pkg::TPS_W'(i + 1),
                                ots_pkg::TIME_W'(i)));
    end
    sender_gap();
    send_request(request(ots_pkg::OP_ATTACH, '0, 32'h0000_1234));
    sender_gap();
    send_request(request(ots_pkg::OP_ATTACH, 24'd5, '0));
    sender_gap();
    send_request(request(ots_pkg::OP_POLL, '0, '1));
    sender_gap();
    send_request(request(ots_pkg::OP_POLL, '1, '0));
    sender_gap();
    send_request(request(ots_pkg::OP_POLL, 24'h5A5A5A, '0));

    tick_plan[0] = '1;
    tick_plan[1] = 24'd1;
    tick_plan[2] = '0;
    tick_plan[3] = ots_pkg::TPS_W'($urandom_range(1, 16777215));
    tick_plan[4] = ots_pkg::TPS_RESET;
    phases = 0;
    for (int p = 0; p < 5; p++) begin
      write_tick_rate(tick_plan[p]);
      phases++;
      if (p == 4) quiet = 1'b1;
      cursor_us = (p == 2) ? 32'hFFFF_F000 : $urandom();
      for (int n = 0; n < 20; n++) begin
        if ((p == 1 && n == 10) || (!quiet && $urandom_range(0, 24) == 0)) drain_replies();
        else sender_gap();
        next_request(it);
        send_request(it);
      end
    end
    drain_replies();
    repeat (60) @(posedge clk);

    $display("run covered %0d requests over %0d time bases: %0d attaches, %0d full",
             sb.requests, phases + 1, sb.attaches_ok, sb.full_seen);
    $display("%0d zero rate, polls gave %0d expiries and %0d empty replies, %0d mismatches",
             sb.zero_rate_seen, sb.expiries, sb.empty_polls, sb.mismatches);
    if (sb.mismatches == 0 && sb.replies_due.size() == 0) begin
      $display("one_shot_timer_slot_table verification clean");
    end else begin
      $display("one_shot_timer_slot_table verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout with %0d replies outstanding", sb.replies_due.size());
    $display("one_shot_timer_slot_table verification failed");
    $finish;
  end

endmodule
